@@ src/bbd_pkg.sv @@
package bbd_pkg;

  localparam int PIXEL_W   = 8;
  localparam int PAIR_W    = 9;
  localparam int SUM_W     = 10;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  typedef enum logic {
    CMD_STORE,
    CMD_EMIT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t             op;
    logic                last;
    logic [PAIR_W-1:0]   pair;
  } cmd_info_t;

  typedef struct packed {
    logic [PIXEL_W-1:0]  value;
    logic                last;
  } out_word_t;

endpackage

@@ src/bayer_block_binning_downsampler.sv @@
// A result passes the command queue, the line-memory read register and the result queue.
// Throughput: one pixel per cycle while full is low; the front and line-memory stage each
// handle one word a cycle when not stalled, joined by a 4-entry command queue, with a 4-entry
// result queue behind. Reset (rst, synchronous): positions and held samples clear, sizes
// return to 640 x 480, both queues empty. The pair-sum line memory is not cleared.
module bayer_block_binning_downsampler #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [bbd_pkg::PIXEL_W-1:0]     pixel,
  input  logic                            pop,
  output logic                            empty,
  output logic [bbd_pkg::PIXEL_W-1:0]     binned_pixel,
  output logic                            last_of_frame,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bbd_pkg::CFG_W-1:0]       cfg_data
);

  import bbd_pkg::*;

  localparam int AW = $clog2(2 * (MAX_WIDTH / 2));
  localparam int CQW = $bits(cmd_info_t) + AW;

  logic                           cmd_push;
  cmd_info_t                      front_info;
  logic [AW-1:0]                  front_idx;
  logic                           cmd_full;
  logic                           cmd_empty;
  logic                           cmd_pop;
  logic [CQW-1:0]                 cmd_word;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;
  cmd_info_t                      back_info;
  logic [AW-1:0]                  back_idx;
  out_word_t                      out_word;

  assign cfg_ready = 1'b1;
  assign full      = cmd_full;

  bbd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .pixel    (pixel),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd_info (front_info),
    .cmd_idx  (front_idx)
  );

  bbd_fifo #(
    .WIDTH(CQW),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .wdata({front_info, front_idx}),
    .pop  (cmd_pop),
    .rdata(cmd_word),
    .empty(cmd_empty),
    .full (cmd_full),
    .count(cmd_count)
  );

  assign back_info = cmd_word[CQW-1:AW];
  assign back_idx  = cmd_word[AW-1:0];

  bbd_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_empty(cmd_empty),
    .cmd_info (back_info),
    .cmd_idx  (back_idx),
    .cmd_pop  (cmd_pop),
    .pop      (pop),
    .empty    (empty),
    .out_word (out_word)
  );

  assign binned_pixel  = out_word.value;
  assign last_of_frame = out_word.last;

  logic unused_count;
  assign unused_count = ^cmd_count;

endmodule

@@ src/bbd_ram.sv @@
module bbd_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ src/bbd_fifo.sv @@
module bbd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

endmodule

@@ src/bbd_front.sv @@
module bbd_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         push,
  input  logic [bbd_pkg::PIXEL_W-1:0]                  pixel,
  input  logic                                         cfg_valid,
  input  logic [bbd_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  logic [bbd_pkg::CFG_W-1:0]                    cfg_data,
  input  logic                                         cmd_full,
  output logic                                         cmd_push,
  output bbd_pkg::cmd_info_t                           cmd_info,
  output logic [$clog2(2*(MAX_WIDTH/2))-1:0]           cmd_idx
);

  import bbd_pkg::*;

  localparam int HALF_LINE = MAX_WIDTH / 2;
  localparam int AW = $clog2(2 * HALF_LINE);
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [CFG_W-1:0]   image_width;
  logic [CFG_W-1:0]   image_height;
  logic [XW-1:0]      column_position;
  logic [YW-1:0]      row_position;
  logic [PIXEL_W-1:0] held [2];

  logic [31:0]        w_full;
  logic [31:0]        h_full;
  logic [WW-1:0]      w;
  logic [HW-1:0]      h;
  logic [WW-1:0]      w4;
  logic [HW-1:0]      h4;
  logic               accept;
  logic               active;
  logic [1:0]         xp;
  logic [1:0]         yp;
  logic [XW:0]        x_inc;
  logic [YW:0]        y_inc;
  logic [XW-1:0]      column_position_next;
  logic [YW-1:0]      row_position_next;

  always_comb begin
    if (image_width < CFG_W'(4)) begin
      w_full = 32'd4;
    end else if ({19'd0, image_width} > 32'(MAX_WIDTH)) begin
      w_full = 32'(MAX_WIDTH);
    end else begin
      w_full = {19'd0, image_width};
    end
    if (image_height < CFG_W'(4)) begin
      h_full = 32'd4;
    end else if ({19'd0, image_height} > 32'(MAX_HEIGHT)) begin
      h_full = 32'(MAX_HEIGHT);
    end else begin
      h_full = {19'd0, image_height};
    end
    w  = w_full[WW-1:0];
    h  = h_full[HW-1:0];
    w4 = {w[WW-1:2], 2'b00};
    h4 = {h[HW-1:2], 2'b00};

    accept = push && !cmd_full;
    active = ({1'b0, column_position} < (XW+1)'(w4)) &&
             ({1'b0, row_position} < (YW+1)'(h4));
    xp = column_position[1:0];
    yp = row_position[1:0];

    cmd_push      = accept && active && xp[1];
    cmd_info.op   = yp[1] ? CMD_EMIT : CMD_STORE;
    cmd_info.pair = {1'b0, held[xp[0]]} + {1'b0, pixel};
    cmd_info.last = ({1'b0, column_position} == (XW+1)'(w4) - 1'b1) &&
                    ({1'b0, row_position} == (YW+1)'(h4) - 1'b1);
    cmd_idx = (yp[0] ? AW'(HALF_LINE) : '0) +
              AW'({column_position[XW-1:2], 1'b0}) +
              AW'(column_position[0]);

    x_inc = {1'b0, column_position} + 1'b1;
    y_inc = {1'b0, row_position} + 1'b1;
    column_position_next = x_inc[XW-1:0];
    row_position_next    = row_position;
    if (x_inc >= (XW+1)'(w)) begin
      column_position_next = '0;
      row_position_next    = y_inc[YW-1:0];
      if (y_inc >= (YW+1)'(h)) begin
        row_position_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= WIDTH_RESET;
      image_height    <= HEIGHT_RESET;
      column_position <= '0;
      row_position    <= '0;
      held[0]         <= '0;
      held[1]         <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          REG_IMAGE_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        column_position <= column_position_next;
        row_position    <= row_position_next;
        if (active && !xp[1]) begin
          held[xp[0]] <= pixel;
        end
      end
    end
  end

endmodule

@@ src/bbd_back.sv @@
module bbd_back #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_empty,
  input  bbd_pkg::cmd_info_t                   cmd_info,
  input  logic [$clog2(2*(MAX_WIDTH/2))-1:0]   cmd_idx,
  output logic                                 cmd_pop,
  input  logic                                 pop,
  output logic                                 empty,
  output bbd_pkg::out_word_t                   out_word
);

  import bbd_pkg::*;

  localparam int LINE_DEPTH = 2 * (MAX_WIDTH / 2);
  localparam int OCW = $clog2(OUT_DEPTH + 1);

  logic [OCW-1:0]    out_count;
  logic              out_full;
  logic              issue;
  logic              s1_valid;
  logic [PAIR_W-1:0] s1_pair;
  logic              s1_last;
  logic [PAIR_W-1:0] line_rdata;
  logic [SUM_W-1:0]  sum;
  out_word_t         res;

  // reserve an output slot for each emit still in the read stage
  assign issue = !cmd_empty &&
                 (cmd_info.op == CMD_STORE ||
                  ({1'b0, out_count} + (OCW+1)'(s1_valid)) < (OCW+1)'(OUT_DEPTH));
  assign cmd_pop = issue;

  bbd_ram #(
    .WIDTH(PAIR_W),
    .DEPTH(LINE_DEPTH)
  ) u_line (
    .clk  (clk),
    .we   (issue && cmd_info.op == CMD_STORE),
    .addr (cmd_idx),
    .wdata(cmd_info.pair),
    .rdata(line_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue && cmd_info.op == CMD_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    s1_pair <= cmd_info.pair;
    s1_last <= cmd_info.last;
  end

  always_comb begin
    sum       = {1'b0, s1_pair} + {1'b0, line_rdata};
    res.value = sum[SUM_W-1:2];
    res.last  = s1_last;
  end

  bbd_fifo #(
    .WIDTH($bits(out_word_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk  (clk),
    .rst  (rst),
    .push (s1_valid),
    .wdata(res),
    .pop  (pop),
    .rdata(out_word),
    .empty(empty),
    .full (out_full),
    .count(out_count)
  );

  logic unused_full;
  assign unused_full = out_full;

endmodule

@@ src/bbd_checker.sv @@
module bbd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        push,
  input logic                        full,
  input logic                        pop,
  input logic                        empty,
  input logic [bbd_pkg::PIXEL_W-1:0] binned_pixel,
  input logic                        last_of_frame
);

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_word_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(binned_pixel) && $stable(last_of_frame))
    else $error("waiting result word changed");

  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    $past(rst) && !push |=> empty)
    else $error("result appeared without input");

endmodule

bind bayer_block_binning_downsampler bbd_checker u_bbd_checker (.*);
